@@ hdl/nde_pkg.sv @@
package nde_pkg;

   localparam logic [3:0] ESCAPE_CODE = 4'h8;

   typedef struct packed {
      logic [7:0] accum;
      logic       high_escape_pending;
      logic       byte_literal_pending;
      logic [3:0] held_nibble;
   } nde_state_type;

   typedef struct packed {
      logic [1:0] count;
      logic [7:0] sample0;
      logic [7:0] sample1;
   } nde_result_type;

   function automatic logic [7:0] add_delta(input logic [7:0] acc, input logic [3:0] nib);
      return acc + {{4{nib[3]}}, nib};
   endfunction

endpackage

@@ hdl/nde_decode.sv @@
module nde_decode (
   input  nde_pkg::nde_state_type  state_cur,
   input  logic [7:0]              data_byte,
   input  logic                    packet_start,
   output nde_pkg::nde_state_type  state_nxt,
   output nde_pkg::nde_result_type result
);
   import nde_pkg::*;

   nde_state_type st;
   logic [3:0]    hi;
   logic [3:0]    lo;
   logic [7:0]    first;

   assign hi = data_byte[7:4];
   assign lo = data_byte[3:0];

   always_comb begin
      st = state_cur;
      if (packet_start) begin
         st = '0;
      end
      state_nxt = st;
      result    = '0;
      first     = '0;
      if (st.high_escape_pending) begin
         first                         = {st.held_nibble, hi};
         state_nxt.high_escape_pending = 1'b0;
      end else if (!st.byte_literal_pending && hi != ESCAPE_CODE) begin
         first = add_delta(st.accum, hi);
      end

      if (st.high_escape_pending || (!st.byte_literal_pending && hi != ESCAPE_CODE)) begin
         result.sample0 = first;
         if (lo == ESCAPE_CODE) begin
            state_nxt.byte_literal_pending = 1'b1;
            state_nxt.accum                = first;
            result.count                   = 2'd1;
         end else begin
            result.sample1  = add_delta(first, lo);
            state_nxt.accum = result.sample1;
            result.count    = 2'd2;
         end
      end else if (st.byte_literal_pending) begin
         state_nxt.byte_literal_pending = 1'b0;
         state_nxt.accum                = data_byte;
         result.sample0                 = data_byte;
         result.count                   = 2'd1;
      end else begin
         state_nxt.held_nibble         = lo;
         state_nxt.high_escape_pending = 1'b1;
      end
   end

endmodule

@@ hdl/nibble_delta_decoder_top.sv @@
// Nibble delta decoder: each byte on req_ is decoded high nibble first into
// zero, one or two 8-bit samples on rsp_, with rsp_tlast set on the final
// sample of each byte. An input register feeds the decoder, whose samples go
// into a two-entry result buffer; the byte advances only when that buffer
// can take all of its samples. Bytes yielding two samples are limited by the
// single result port: the next byte loads only as the second sample is taken.
// Bytes yielding zero or one sample can be taken every cycle while rsp_tready
// stays high. req_tuser set first clears accumulator and any pending escape.
module nibble_delta_decoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] data_byte
   input  logic       req_tuser,  // [0] packet_start
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [7:0] sample
   output logic       rsp_tlast   // last_of_run
);
   import nde_pkg::*;

   logic           in_vld_ff, in_vld_in;
   logic [7:0]     in_byte_ff;
   logic           in_start_ff;
   nde_state_type  state_ff, state_in;
   nde_result_type res;
   logic [1:0]     buf_cnt_ff, buf_cnt_in;
   logic [7:0]     buf_s0_ff, buf_s0_in;
   logic [7:0]     buf_s1_ff, buf_s1_in;
   logic           rsp_take;
   logic           load;
   logic           req_take;

   nde_decode u_decode (
      .state_cur    (state_ff),
      .data_byte    (in_byte_ff),
      .packet_start (in_start_ff),
      .state_nxt    (state_in),
      .result       (res)
   );

   assign rsp_take   = rsp_tvalid && rsp_tready;
   assign load       = in_vld_ff && (buf_cnt_ff == 2'd0 || (buf_cnt_ff == 2'd1 && rsp_take));
   assign req_tready = !in_vld_ff || load;
   assign req_take   = req_tvalid && req_tready;
   assign in_vld_in  = req_take || (in_vld_ff && !load);

   assign rsp_tvalid = buf_cnt_ff != 2'd0;
   assign rsp_tdata  = buf_s0_ff;
   assign rsp_tlast  = buf_cnt_ff == 2'd1;

   always_comb begin
      buf_cnt_in = buf_cnt_ff;
      buf_s0_in  = buf_s0_ff;
      buf_s1_in  = buf_s1_ff;
      if (load) begin
         buf_cnt_in = res.count;
         buf_s0_in  = res.sample0;
         buf_s1_in  = res.sample1;
      end else if (rsp_take) begin
         buf_cnt_in = buf_cnt_ff - 2'd1;
         buf_s0_in  = buf_s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         state_ff   <= '0;
         buf_cnt_ff <= 2'd0;
      end else begin
         in_vld_ff  <= in_vld_in;
         buf_cnt_ff <= buf_cnt_in;
         if (load) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
      buf_s0_ff <= buf_s0_in;
      buf_s1_ff <= buf_s1_in;
   end

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      buf_cnt_ff != 2'd3)
      else $error("result buffer count out of range");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(state_ff.high_escape_pending && state_ff.byte_literal_pending))
      else $error("both escape flags set");

   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_take && buf_cnt_ff == 2'd2 |=> rsp_tvalid && buf_cnt_ff == 2'd1)
      else $error("second sample of item lost");

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      load |=> buf_cnt_ff == $past(res.count))
      else $error("result buffer count not loaded");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !load |=> in_vld_ff && $stable(in_byte_ff))
      else $error("pending item dropped");
`endif

endmodule
